### rtl/core/bstk_pkg.sv
// ----------------------------------------------------------------------------
// bstk_pkg
// Shared constants, codes and item types of the bounded stack with search.
// ----------------------------------------------------------------------------
package bstk_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W     = $clog2(DEPTH);

  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_READ   = 2'd2,
    KIND_SEARCH = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_OVERFLOW  = 3'd1,
    STATUS_UNDERFLOW = 3'd2,
    STATUS_BADPOS    = 3'd3,
    STATUS_NOTFOUND  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_SEARCH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]            kind;
    logic [DATA_WIDTH-1:0] data_in;
    logic [CNT_W-1:0]      position;
  } req_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [DATA_WIDTH-1:0] data_out;
    logic [CNT_W-1:0]      found_position;
    logic [CNT_W-1:0]      count;
    logic                  empty_res;
    logic                  full_res;
    logic [DATA_WIDTH-1:0] top_value;
  } rsp_t;

endpackage

### rtl/core/bounded_stack_with_search.sv
// ----------------------------------------------------------------------------
// bounded_stack_with_search
// Bounded LIFO stack in a synchronous RAM with push, pop, indexed read and
// search for the lowest matching entry.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------
//  request | req_valid_i / req_ready_o  | req_i : kind, data_in, position
//  result  | rsp_valid_o / rsp_ready_i  | rsp_o : status, data_out, found_pos,
//          |                            |         count, empty, full, top
//
//  Push, overflow, underflow, bad-position and last-entry pop items finish
//  without a RAM read; other pops and reads wait for the registered RAM read.
//  Search compares entries one by one, walking up from the bottom.
//  Reset clears the entry count and top register; the RAM is not cleared, as
//  only entries below the count are ever read.
//  A result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module bounded_stack_with_search (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  bstk_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output bstk_pkg::rsp_t rsp_o
);

  // controller to output register
  logic                                ctrl_valid;
  logic                                ctrl_ready;
  bstk_pkg::rsp_t                      ctrl_rsp;

  // controller to RAM
  logic                                ram_we;
  logic [bstk_pkg::ADDR_W-1:0]         ram_waddr;
  logic [bstk_pkg::DATA_WIDTH-1:0]     ram_wdata;
  logic                                ram_re;
  logic [bstk_pkg::ADDR_W-1:0]         ram_raddr;
  logic [bstk_pkg::DATA_WIDTH-1:0]     ram_rdata;

  // output register
  logic                                out_valid_q, out_valid_d;
  bstk_pkg::rsp_t                      out_q;

  bstk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (ctrl_valid),
    .rsp_ready_i (ctrl_ready),
    .rsp_o       (ctrl_rsp),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  bstk_ram #(
    .Depth (bstk_pkg::DEPTH),
    .Width (bstk_pkg::DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Take a new result when the slot is empty or drains this cycle.
  assign ctrl_ready = !out_valid_q || rsp_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_valid && ctrl_ready) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Load the payload only on transfer; hold it while stalled.
  always_ff @(posedge clk_i) begin
    if (ctrl_valid && ctrl_ready) begin
      out_q <= ctrl_rsp;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

endmodule

### rtl/core/bstk_ram.sv
// ----------------------------------------------------------------------------
// bstk_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module bstk_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 32,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/bstk_ctrl.sv
// ----------------------------------------------------------------------------
// bstk_ctrl
// Request sequencer: count and top registers, RAM access, search walk.
// ----------------------------------------------------------------------------
module bstk_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                req_valid_i,
  output logic                                req_ready_o,
  input  bstk_pkg::req_t                      req_i,
  output logic                                rsp_valid_o,
  input  logic                                rsp_ready_i,
  output bstk_pkg::rsp_t                      rsp_o,
  output logic                                ram_we_o,
  output logic [bstk_pkg::ADDR_W-1:0]         ram_waddr_o,
  output logic [bstk_pkg::DATA_WIDTH-1:0]     ram_wdata_o,
  output logic                                ram_re_o,
  output logic [bstk_pkg::ADDR_W-1:0]         ram_raddr_o,
  input  logic [bstk_pkg::DATA_WIDTH-1:0]     ram_rdata_i
);

  bstk_pkg::state_e                  state_q, state_d;
  bstk_pkg::kind_e                   op_q, op_d;
  logic [bstk_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [bstk_pkg::DATA_WIDTH-1:0]   top_q, top_d;
  logic [bstk_pkg::DATA_WIDTH-1:0]   key_q, key_d;
  logic [bstk_pkg::ADDR_W-1:0]       srch_q, srch_d;
  bstk_pkg::status_e                 status_q, status_d;
  logic [bstk_pkg::DATA_WIDTH-1:0]   dout_q, dout_d;
  logic [bstk_pkg::CNT_W-1:0]        fpos_q, fpos_d;

  logic                              full;
  logic [bstk_pkg::CNT_W-1:0]        pop_addr;
  logic [bstk_pkg::CNT_W-1:0]        rd_addr;
  logic [bstk_pkg::CNT_W-1:0]        srch_nxt;

  assign full     = (cnt_q == bstk_pkg::CNT_W'(bstk_pkg::DEPTH));
  assign pop_addr = cnt_q - bstk_pkg::CNT_W'(2);
  assign rd_addr  = req_i.position - bstk_pkg::CNT_W'(1);
  assign srch_nxt = bstk_pkg::CNT_W'(srch_q) + bstk_pkg::CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    top_d       = top_q;
    key_d       = key_q;
    srch_d      = srch_q;
    status_d    = status_q;
    dout_d      = dout_q;
    fpos_d      = fpos_q;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = cnt_q[bstk_pkg::ADDR_W-1:0];
    ram_wdata_o = req_i.data_in;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;

    unique case (state_q)
      bstk_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          op_d     = bstk_pkg::kind_e'(req_i.kind);
          status_d = bstk_pkg::STATUS_OK;
          dout_d   = '0;
          fpos_d   = '0;
          state_d  = bstk_pkg::ST_DONE;
          unique case (bstk_pkg::kind_e'(req_i.kind))
            bstk_pkg::KIND_PUSH: begin
              if (full) begin
                status_d = bstk_pkg::STATUS_OVERFLOW;
              end else begin
                ram_we_o = 1'b1;
                cnt_d    = cnt_q + bstk_pkg::CNT_W'(1);
                top_d    = req_i.data_in;
              end
            end
            bstk_pkg::KIND_POP: begin
              if (cnt_q == '0) begin
                status_d = bstk_pkg::STATUS_UNDERFLOW;
              end else begin
                dout_d = top_q;
                cnt_d  = cnt_q - bstk_pkg::CNT_W'(1);
                if (cnt_q == bstk_pkg::CNT_W'(1)) begin
                  top_d = '0;
                end else begin
                  // fetch the entry that becomes the new top
                  ram_re_o    = 1'b1;
                  ram_raddr_o = pop_addr[bstk_pkg::ADDR_W-1:0];
                  state_d     = bstk_pkg::ST_RDWAIT;
                end
              end
            end
            bstk_pkg::KIND_READ: begin
              if (req_i.position == '0 || req_i.position > cnt_q) begin
                status_d = bstk_pkg::STATUS_BADPOS;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = rd_addr[bstk_pkg::ADDR_W-1:0];
                state_d     = bstk_pkg::ST_RDWAIT;
              end
            end
            bstk_pkg::KIND_SEARCH: begin
              key_d = req_i.data_in;
              if (cnt_q == '0) begin
                status_d = bstk_pkg::STATUS_NOTFOUND;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = '0;
                srch_d      = '0;
                state_d     = bstk_pkg::ST_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end

      bstk_pkg::ST_RDWAIT: begin
        if (op_q == bstk_pkg::KIND_POP) begin
          top_d = ram_rdata_i;
        end else begin
          dout_d = ram_rdata_i;
        end
        state_d = bstk_pkg::ST_DONE;
      end

      bstk_pkg::ST_SEARCH: begin
        // rdata holds the entry at srch_q; compare, then advance or stop
        if (ram_rdata_i == key_q) begin
          fpos_d  = srch_nxt;
          state_d = bstk_pkg::ST_DONE;
        end else if (srch_nxt == cnt_q) begin
          status_d = bstk_pkg::STATUS_NOTFOUND;
          state_d  = bstk_pkg::ST_DONE;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = srch_nxt[bstk_pkg::ADDR_W-1:0];
          srch_d      = srch_nxt[bstk_pkg::ADDR_W-1:0];
        end
      end

      bstk_pkg::ST_DONE: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = bstk_pkg::ST_IDLE;
        end
      end

      default: state_d = bstk_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bstk_pkg::ST_IDLE;
      cnt_q   <= '0;
      top_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      top_q   <= top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    srch_q   <= srch_d;
    status_q <= status_d;
    dout_q   <= dout_d;
    fpos_q   <= fpos_d;
  end

  always_comb begin
    rsp_o.status         = status_q;
    rsp_o.data_out       = dout_q;
    rsp_o.found_position = fpos_q;
    rsp_o.count          = cnt_q;
    rsp_o.empty_res      = (cnt_q == '0);
    rsp_o.full_res       = full;
    rsp_o.top_value      = top_q;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= bstk_pkg::CNT_W'(bstk_pkg::DEPTH))
    else $error("entry count above depth");

  a_top_zero_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (top_q == '0))
    else $error("top value not zero on empty stack");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o && req_i.kind == bstk_pkg::KIND_PUSH && !full)
    |=> (cnt_q == $past(cnt_q) + bstk_pkg::CNT_W'(1)))
    else $error("push did not advance count");

  a_search_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bstk_pkg::ST_SEARCH) |-> (bstk_pkg::CNT_W'(srch_q) < cnt_q))
    else $error("search walked past the top");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded stack with push, pop, indexed read and
// search. A shadow stack predicts every result. A short table of requests
// covers empty, full and bad-position cases. Random requests follow, with
// bursts that fill and drain the stack and with idle and stall phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned ITEMS_PER_SET = 125;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned DRAIN_CYCLES  = 40;

  // One row of the directed table: a request and, where it is obvious,
  // the result typed in by hand.
  typedef struct {
    bstk_pkg::kind_e                 kind;
    logic [bstk_pkg::DATA_WIDTH-1:0] data;
    logic [bstk_pkg::CNT_W-1:0]      pos;
    bit                              typed;
    bstk_pkg::rsp_t                  want;
  } dir_row_t;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           req_valid_i = 1'b0;
  logic           rsp_ready_i = 1'b0;
  bstk_pkg::req_t req_i       = '0;
  logic           req_ready_o;
  logic           rsp_valid_o;
  bstk_pkg::rsp_t rsp_o;

  // Shadow copy of the stack contents and fill level.
  logic [bstk_pkg::DATA_WIDTH-1:0] shadow_stack [bstk_pkg::DEPTH];
  int unsigned                     shadow_count = 0;

  bstk_pkg::rsp_t pending_results [$];
  dir_row_t directed [$];

  int          idle_pct      = 0;
  int          stall_pct     = 0;
  bit          pressure_req  = 1'b0;
  int unsigned hold_count    = 0;
  int unsigned fail_count    = 0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned kind_seen [4] = '{default: 0};
  int unsigned status_seen [5] = '{default: 0};

  bounded_stack_with_search dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction: apply one request to the shadow stack and build its result.
  // --------------------------------------------------------------------------
  function automatic bstk_pkg::rsp_t predict_result(input bstk_pkg::req_t r);
    bstk_pkg::rsp_t res;
    int unsigned    idx;
    res = '0;
    case (bstk_pkg::kind_e'(r.kind))
      bstk_pkg::KIND_PUSH: begin
        if (shadow_count >= bstk_pkg::DEPTH) begin
          res.status = bstk_pkg::STATUS_OVERFLOW;
        end else begin
          shadow_stack[shadow_count] = r.data_in;
          shadow_count++;
        end
      end
      bstk_pkg::KIND_POP: begin
        if (shadow_count == 0) begin
          res.status = bstk_pkg::STATUS_UNDERFLOW;
        end else begin
          res.data_out = shadow_stack[shadow_count-1];
          shadow_count--;
        end
      end
      bstk_pkg::KIND_READ: begin
        // Position count+1 is rejected as well.
        if (r.position < 1 || r.position > shadow_count) begin
          res.status = bstk_pkg::STATUS_BADPOS;
        end else begin
          res.data_out = shadow_stack[r.position-1];
        end
      end
      default: begin
        // Walk up from the bottom; the lowest match wins.
        res.status = bstk_pkg::STATUS_NOTFOUND;
        for (idx = 0; idx < shadow_count && res.found_position == 0; idx++) begin
          if (shadow_stack[idx] == r.data_in) begin
            res.status         = bstk_pkg::STATUS_OK;
            res.found_position = bstk_pkg::CNT_W'(idx + 1);
          end
        end
      end
    endcase
    res.count     = bstk_pkg::CNT_W'(shadow_count);
    res.empty_res = (shadow_count == 0);
    res.full_res  = (shadow_count >= bstk_pkg::DEPTH);
    res.top_value = (shadow_count != 0) ? shadow_stack[shadow_count-1] : '0;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Random request shaped by the shadow state: reads mostly hit live
  // positions, searches mostly look for stored values, and a small pool of
  // push values makes duplicates so the lowest-match rule gets exercised.
  // --------------------------------------------------------------------------
  function automatic bstk_pkg::req_t random_request(input int push_bias);
    bstk_pkg::req_t r;
    int             pick;
    r.data_in  = $urandom;
    r.position = bstk_pkg::CNT_W'($urandom_range(0, bstk_pkg::DEPTH));
    pick = $urandom_range(99);
    if (pick < 60) begin
      r.kind = ($urandom_range(99) < push_bias) ? bstk_pkg::KIND_PUSH : bstk_pkg::KIND_POP;
    end else if (pick < 80) begin
      r.kind = bstk_pkg::KIND_READ;
    end else begin
      r.kind = bstk_pkg::KIND_SEARCH;
    end
    if ($urandom_range(99) < 40) begin
      r.data_in = $urandom_range(0, 7);
    end
    if (r.kind == bstk_pkg::KIND_SEARCH && shadow_count > 0 && $urandom_range(99) < 70) begin
      r.data_in = shadow_stack[$urandom_range(0, shadow_count - 1)];
    end
    if (r.kind == bstk_pkg::KIND_READ && shadow_count > 0 && $urandom_range(99) < 75) begin
      r.position = bstk_pkg::CNT_W'($urandom_range(1, shadow_count));
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Send one item. Entered at a falling edge with valid possibly still high
  // from the item just taken; valid is only lowered when a gap is inserted,
  // so it never sees two updates in one step.
  // --------------------------------------------------------------------------
  task automatic send_req(input bstk_pkg::req_t r, input bit typed,
                          input bstk_pkg::rsp_t want);
    int             gap;
    bstk_pkg::rsp_t predicted;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    // Hold the item until the block takes it.
    do @(posedge clk_i); while (!req_ready_o);
    predicted = predict_result(r);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
    kind_seen[r.kind]++;
    @(negedge clk_i);
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("[%0t] ERROR: %s", $time, msg);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, plus one long hold-off counted here so the
  // block backs up and stops taking requests.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (pressure_req && hold_count < HOLD_CYCLES) begin
      rsp_ready_i <= 1'b0;
      hold_count++;
    end else begin
      rsp_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each taken result with the oldest expectation, field by field.
  always @(posedge clk_i) begin
    bstk_pkg::rsp_t want;
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      results_seen++;
      if (rsp_o.status < 5) begin
        status_seen[rsp_o.status]++;
      end
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result with nothing pending: st=%0d dout=%h cnt=%0d",
                               rsp_o.status, rsp_o.data_out, rsp_o.count));
      end else begin
        want = pending_results.pop_front();
        if (rsp_o.status !== want.status || rsp_o.data_out !== want.data_out ||
            rsp_o.found_position !== want.found_position ||
            rsp_o.count !== want.count || rsp_o.empty_res !== want.empty_res ||
            rsp_o.full_res !== want.full_res || rsp_o.top_value !== want.top_value) begin
          note_failure({
            $sformatf("result %0d: expected st=%0d dout=%h fpos=%0d cnt=%0d e=%b f=%b top=%h",
                      results_seen, want.status, want.data_out, want.found_position,
                      want.count, want.empty_res, want.full_res, want.top_value),
            $sformatf(", got st=%0d dout=%h fpos=%0d cnt=%0d e=%b f=%b top=%h",
                      rsp_o.status, rsp_o.data_out, rsp_o.found_position, rsp_o.count,
                      rsp_o.empty_res, rsp_o.full_res, rsp_o.top_value)});
        end
      end
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("bounded_stack_with_search test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    bstk_pkg::req_t r;
    int             push_bias;
    int             set_idx;
    int             n;

    // Directed table. Typed rows: empty-stack errors, first push of all ones,
    // bad positions zero and count+1, and overflow on a full stack.
    directed.push_back('{bstk_pkg::KIND_POP, 32'h0, 5'd0, 1'b1,
      '{bstk_pkg::STATUS_UNDERFLOW, 32'h0, 5'd0, 5'd0, 1'b1, 1'b0, 32'h0}});
    directed.push_back('{bstk_pkg::KIND_READ, 32'h0, 5'd1, 1'b1,
      '{bstk_pkg::STATUS_BADPOS, 32'h0, 5'd0, 5'd0, 1'b1, 1'b0, 32'h0}});
    directed.push_back('{bstk_pkg::KIND_SEARCH, 32'h0, 5'd0, 1'b1,
      '{bstk_pkg::STATUS_NOTFOUND, 32'h0, 5'd0, 5'd0, 1'b1, 1'b0, 32'h0}});
    directed.push_back('{bstk_pkg::KIND_PUSH, 32'hFFFF_FFFF, 5'd0, 1'b1,
      '{bstk_pkg::STATUS_OK, 32'h0, 5'd0, 5'd1, 1'b0, 1'b0, 32'hFFFF_FFFF}});
    directed.push_back('{bstk_pkg::KIND_READ, 32'h0, 5'd0, 1'b1,
      '{bstk_pkg::STATUS_BADPOS, 32'h0, 5'd0, 5'd1, 1'b0, 1'b0, 32'hFFFF_FFFF}});
    directed.push_back('{bstk_pkg::KIND_READ, 32'h0, 5'd2, 1'b1,
      '{bstk_pkg::STATUS_BADPOS, 32'h0, 5'd0, 5'd1, 1'b0, 1'b0, 32'hFFFF_FFFF}});
    directed.push_back('{bstk_pkg::KIND_READ, 32'h0, 5'd1, 1'b1,
      '{bstk_pkg::STATUS_OK, 32'hFFFF_FFFF, 5'd0, 5'd1, 1'b0, 1'b0, 32'hFFFF_FFFF}});
    directed.push_back('{bstk_pkg::KIND_SEARCH, 32'hFFFF_FFFF, 5'd0, 1'b1,
      '{bstk_pkg::STATUS_OK, 32'h0, 5'd1, 5'd1, 1'b0, 1'b0, 32'hFFFF_FFFF}});
    directed.push_back('{bstk_pkg::KIND_PUSH, 32'h0, 5'd0, 1'b1,
      '{bstk_pkg::STATUS_OK, 32'h0, 5'd0, 5'd2, 1'b0, 1'b0, 32'h0}});
    // Fill to the top; one more all-ones entry so search must pick the lower.
    for (n = 3; n <= bstk_pkg::DEPTH; n++) begin
      directed.push_back('{bstk_pkg::KIND_PUSH,
                           (n == 9) ? 32'hFFFF_FFFF : (32'h8000_0000 | n),
                           5'd0, 1'b0, '0});
    end
    directed.push_back('{bstk_pkg::KIND_PUSH, 32'h1234_5678, 5'd0, 1'b1,
      '{bstk_pkg::STATUS_OVERFLOW, 32'h0, 5'd0, 5'd16, 1'b0, 1'b1, 32'h8000_0010}});
    directed.push_back('{bstk_pkg::KIND_READ,   32'h0, 5'd16, 1'b0, '0});
    directed.push_back('{bstk_pkg::KIND_SEARCH, 32'hFFFF_FFFF, 5'd0, 1'b0, '0});
    directed.push_back('{bstk_pkg::KIND_POP,    32'h0, 5'd0, 1'b0, '0});

    // Hold reset, then release it at a falling edge.
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      r.kind     = directed[i].kind;
      r.data_in  = directed[i].data;
      r.position = directed[i].pos;
      send_req(r, directed[i].typed, directed[i].want);
    end

    // Random sets: no idling (with the long hold-off), sender idle,
    // receiver stalling, both.
    push_bias = 50;
    for (set_idx = 0; set_idx < 4; set_idx++) begin
      case (set_idx)
        0: begin idle_pct = 0;  stall_pct = 0;  pressure_req = 1'b1; end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      for (n = 0; n < ITEMS_PER_SET; n++) begin
        // Re-pick the push bias now and then to sweep between empty and full.
        if (n % 16 == 0) begin
          case ($urandom_range(2))
            0: push_bias = 15;
            1: push_bias = 50;
            default: push_bias = 85;
          endcase
        end
        send_req(random_request(push_bias), 1'b0, '0);
      end
    end
    req_valid_i <= 1'b0;

    // Drain, then allow the block's latency to pass.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests (push %0d, pop %0d, read %0d, search %0d), checked %0d.",
             items_sent, kind_seen[bstk_pkg::KIND_PUSH], kind_seen[bstk_pkg::KIND_POP],
             kind_seen[bstk_pkg::KIND_READ], kind_seen[bstk_pkg::KIND_SEARCH],
             results_seen);
    $display("Status mix: ok %0d, overflow %0d, underflow %0d, bad pos %0d, not found %0d.",
             status_seen[bstk_pkg::STATUS_OK], status_seen[bstk_pkg::STATUS_OVERFLOW],
             status_seen[bstk_pkg::STATUS_UNDERFLOW], status_seen[bstk_pkg::STATUS_BADPOS],
             status_seen[bstk_pkg::STATUS_NOTFOUND]);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("bounded_stack_with_search test passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("bounded_stack_with_search test failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/bstk_pkg.sv
rtl/core/bstk_ram.sv
rtl/core/bstk_ctrl.sv
rtl/core/bounded_stack_with_search.sv
tb/tb.sv
